### rtl/core/dcts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcts_pkg
// Shared types, codes and character constants of the doc comment token scanner.
// ----------------------------------------------------------------------------
package dcts_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int DEPTH_BITS_DEF = 8;

	localparam int CP_BITS  = 21;
	localparam int OUT_BITS = 16;

	// token kind codes
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_TYPE    = 2'd1;
	localparam logic [1:0] KIND_EXAMPLE = 2'd2;

	// characters of interest
	localparam logic [CP_BITS-1:0] CHR_LBRACE = 21'h00007B;
	localparam logic [CP_BITS-1:0] CHR_RBRACE = 21'h00007D;
	localparam logic [CP_BITS-1:0] CHR_LF     = 21'h00000A;
	localparam logic [CP_BITS-1:0] CHR_CR     = 21'h00000D;
	localparam logic [CP_BITS-1:0] CHR_NUL    = 21'h000000;
	localparam logic [CP_BITS-1:0] CHR_AT     = 21'h000040;
	localparam logic [CP_BITS-1:0] CHR_TICK   = 21'h000060;
	localparam logic [CP_BITS-1:0] CHR_STAR   = 21'h00002A;
	localparam logic [CP_BITS-1:0] CHR_SLASH  = 21'h00002F;
	localparam logic [CP_BITS-1:0] CHR_TAB    = 21'h000009;
	localparam logic [CP_BITS-1:0] CHR_SPACE  = 21'h000020;

	typedef struct packed {
		logic [CP_BITS-1:0] ch;
		logic               at_end;
		logic               want_example;
		logic               want_type;
	} dcts_item_t;

	typedef struct packed {
		logic [1:0]          token_kind;
		logic [OUT_BITS-1:0] skip_count;
		logic [OUT_BITS-1:0] token_length;
	} dcts_result_t;

	typedef struct packed {
		logic       valid;
		dcts_item_t item;
	} dcts_item_slot_t;

	typedef struct packed {
		logic         valid;
		dcts_result_t result;
	} dcts_result_slot_t;

endpackage
`default_nettype wire

### rtl/core/dcts_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcts_item_if / dcts_result_if
// Valid/ready channels that carry one scanner item or one scanner result.
// ----------------------------------------------------------------------------
interface dcts_item_if;
	logic        valid;
	logic        ready;
	logic [20:0] ch;
	logic        at_end;
	logic        want_example;
	logic        want_type;

	modport source (output valid, output ch, output at_end, output want_example,
		output want_type, input ready);
	modport sink (input valid, input ch, input at_end, input want_example,
		input want_type, output ready);
endinterface

interface dcts_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [15:0] skip_count;
	logic [15:0] token_length;

	modport source (output valid, output token_kind, output skip_count,
		output token_length, input ready);
	modport sink (input valid, input token_kind, input skip_count,
		input token_length, output ready);
endinterface
`default_nettype wire

### rtl/core/dcts_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcts_in_reg
// Input register: holds one accepted item until the scan step consumes it.
// ----------------------------------------------------------------------------
module dcts_in_reg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire dcts_pkg::dcts_item_t  in_item,
	input  wire                        consume,
	output dcts_pkg::dcts_item_slot_t  slot_s1
);
	import dcts_pkg::*;

	logic       valid_s1;
	dcts_item_t item_s1;

	assign in_ready = !valid_s1 || consume;
	assign slot_s1  = '{valid: valid_s1, item: item_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

### rtl/core/dcts_scan_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcts_scan_core
// Scan state and the per-character step; one character is resolved per cycle while the result register is free.
// ----------------------------------------------------------------------------
module dcts_scan_core #(
	parameter int COUNT_BITS = dcts_pkg::COUNT_BITS_DEF,
	parameter int DEPTH_BITS = dcts_pkg::DEPTH_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire dcts_pkg::dcts_item_slot_t slot_s1,
	input  wire                          out_free,
	output logic                         consume,
	output dcts_pkg::dcts_result_slot_t  res
);
	import dcts_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_SKIP     = 4'd1,
		PH_SKIPSTAR = 4'd2,
		PH_BODY     = 4'd3,
		PH_BODYSTAR = 4'd4,
		PH_CR       = 4'd5,
		PH_PREFIX   = 4'd6,
		PH_PSTAR    = 4'd7,
		PH_TYPE     = 4'd8
	} phase_t;

	phase_t                phase_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [COUNT_BITS-1:0] adv_q;
	logic [COUNT_BITS-1:0] mark_q;
	logic [COUNT_BITS-1:0] skip_q;
	logic                  content_q;
	logic                  type_ok_q;

	phase_t                ph;
	logic [DEPTH_BITS-1:0] dep;
	logic [COUNT_BITS-1:0] adv;
	logic [COUNT_BITS-1:0] mark;
	logic [COUNT_BITS-1:0] skip;
	logic                  cont;
	logic                  ty;
	logic                  live;
	logic                  concl;
	logic [1:0]            kind;

	logic e;
	logic is_sp, is_tab, is_lf, is_cr, is_star, is_slash, is_at, is_tick;
	logic is_lb, is_rb, is_nul;

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [OUT_BITS-1:0] clip(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_BITS-1:0] w;
		w = {{OUT_BITS{1'b0}}, v};
		return (w > (COUNT_BITS+OUT_BITS)'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
			: w[OUT_BITS-1:0];
	endfunction

	assign consume = slot_s1.valid && out_free;

	// character classes, all false at end of input
	assign e        = slot_s1.item.at_end;
	assign is_sp    = !e && slot_s1.item.ch == CHR_SPACE;
	assign is_tab   = !e && slot_s1.item.ch == CHR_TAB;
	assign is_lf    = !e && slot_s1.item.ch == CHR_LF;
	assign is_cr    = !e && slot_s1.item.ch == CHR_CR;
	assign is_star  = !e && slot_s1.item.ch == CHR_STAR;
	assign is_slash = !e && slot_s1.item.ch == CHR_SLASH;
	assign is_at    = !e && slot_s1.item.ch == CHR_AT;
	assign is_tick  = !e && slot_s1.item.ch == CHR_TICK;
	assign is_lb    = !e && slot_s1.item.ch == CHR_LBRACE;
	assign is_rb    = !e && slot_s1.item.ch == CHR_RBRACE;
	assign is_nul   = !e && slot_s1.item.ch == CHR_NUL;

	// phases are resolved in an order where every pass-through goes forward,
	// so one sweep settles the character
	always_comb begin
		ph    = phase_q;
		dep   = depth_q;
		adv   = adv_q;
		mark  = mark_q;
		skip  = skip_q;
		cont  = content_q;
		ty    = type_ok_q;
		live  = 1'b1;
		concl = 1'b0;
		kind  = KIND_NONE;

		if (ph == PH_IDLE) begin
			ty = slot_s1.item.want_type;
			if (slot_s1.item.want_example) begin
				ph = PH_SKIP;
			end else if (ty) begin
				ph = PH_TYPE;
			end else begin
				concl = 1'b1;
				live  = 1'b0;
			end
		end

		if (live && ph == PH_SKIPSTAR) begin
			if (is_slash) begin
				if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else begin
				ph = PH_SKIP;
			end
		end

		if (live && ph == PH_SKIP) begin
			if (e || is_at || is_tick) begin
				if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else if (is_sp || is_tab || is_lf || is_cr) begin
				skip = bump(skip);
				live = 1'b0;
			end else if (is_star) begin
				skip = bump(skip);
				ph   = PH_SKIPSTAR;
				live = 1'b0;
			end else begin
				adv  = bump(adv);
				mark = adv;
				cont = 1'b1;
				ph   = PH_BODY;
				live = 1'b0;
			end
		end

		if (live && ph == PH_BODYSTAR) begin
			if (is_slash) begin
				if (cont) begin
					kind  = KIND_EXAMPLE;
					concl = 1'b1;
					live  = 1'b0;
				end else if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else begin
				mark = adv;
				cont = 1'b1;
				ph   = PH_BODY;
			end
		end

		if (live && ph == PH_CR) begin
			if (is_lf) begin
				adv  = bump(adv);
				live = 1'b0;
			end
			ph = PH_PREFIX;
		end

		if (live && ph == PH_PSTAR) begin
			if (is_slash) begin
				if (cont) begin
					kind  = KIND_EXAMPLE;
					concl = 1'b1;
					live  = 1'b0;
				end else if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else begin
				ph = PH_PREFIX;
			end
		end

		if (live && ph == PH_PREFIX) begin
			if (is_sp || is_tab) begin
				adv  = bump(adv);
				live = 1'b0;
			end else if (is_star) begin
				adv  = bump(adv);
				ph   = PH_PSTAR;
				live = 1'b0;
			end else if (e || is_at) begin
				if (cont) begin
					kind  = KIND_EXAMPLE;
					concl = 1'b1;
					live  = 1'b0;
				end else if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else begin
				ph = PH_BODY;
			end
		end

		if (live && ph == PH_BODY) begin
			if (e) begin
				if (cont) begin
					kind  = KIND_EXAMPLE;
					concl = 1'b1;
					live  = 1'b0;
				end else if (ty) begin
					ph = PH_TYPE;
				end else begin
					concl = 1'b1;
					live  = 1'b0;
				end
			end else begin
				adv  = bump(adv);
				live = 1'b0;
				if (is_star) begin
					ph = PH_BODYSTAR;
				end else if (is_lf) begin
					ph = PH_PREFIX;
				end else if (is_cr) begin
					ph = PH_CR;
				end else begin
					mark = adv;
					cont = 1'b1;
				end
			end
		end

		if (live && ph == PH_TYPE) begin
			live = 1'b0;
			if (e || is_lf || is_nul) begin
				concl = 1'b1;
			end else if (is_lb && (&dep)) begin
				concl = 1'b1;
			end else if (is_rb && dep == '0) begin
				kind  = KIND_TYPE;
				concl = 1'b1;
			end else begin
				if (is_lb) begin
					dep = dep + DEPTH_BITS'(1);
				end else if (is_rb) begin
					dep = dep - DEPTH_BITS'(1);
				end
				adv = bump(adv);
			end
		end

		// unused phase codes conclude with no token
		if (live) begin
			concl = 1'b1;
			kind  = KIND_NONE;
		end
	end

	always_comb begin
		res.valid               = consume && concl;
		res.result.token_kind   = kind;
		res.result.skip_count   = '0;
		res.result.token_length = '0;
		case (kind)
			KIND_EXAMPLE: begin
				res.result.skip_count   = clip(skip);
				res.result.token_length = clip(mark);
			end
			KIND_TYPE: begin
				res.result.skip_count   = clip(skip);
				res.result.token_length = clip(adv);
			end
			default: begin
				res.result.skip_count   = '0;
				res.result.token_length = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			depth_q   <= '0;
			adv_q     <= '0;
			mark_q    <= '0;
			skip_q    <= '0;
			content_q <= 1'b0;
			type_ok_q <= 1'b0;
		end else if (consume) begin
			if (concl) begin
				phase_q   <= PH_IDLE;
				depth_q   <= '0;
				adv_q     <= '0;
				mark_q    <= '0;
				skip_q    <= '0;
				content_q <= 1'b0;
				type_ok_q <= 1'b0;
			end else begin
				phase_q   <= ph;
				depth_q   <= dep;
				adv_q     <= adv;
				mark_q    <= mark;
				skip_q    <= skip;
				content_q <= cont;
				type_ok_q <= ty;
			end
		end
	end

`ifndef SYNTH
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> phase_q == PH_IDLE)
		else $error("scan state not cleared after a result");

	a_depth_only_in_type: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q != '0 |-> phase_q == PH_TYPE)
		else $error("brace depth outside the type scan");

	a_mark_behind_advance: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= adv_q)
		else $error("marked end beyond advance count");

	a_body_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY || phase_q == PH_BODYSTAR || phase_q == PH_CR ||
		 phase_q == PH_PREFIX || phase_q == PH_PSTAR) |-> content_q)
		else $error("body phase without content");

	a_no_step_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!slot_s1.valid |=> $stable(phase_q))
		else $error("scan state moved without an item");
`endif

endmodule
`default_nettype wire

### rtl/core/dcts_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcts_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module dcts_out_reg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire dcts_pkg::dcts_result_slot_t res,
	output logic                             out_free,
	output logic                             out_valid,
	input  wire                              out_ready,
	output dcts_pkg::dcts_result_t           out_result
);
	import dcts_pkg::*;

	logic         valid_q;
	dcts_result_t result_q;

	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			result_q <= res.result;
		end
	end

endmodule
`default_nettype wire

### rtl/core/doc_comment_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// doc_comment_token_scanner
// Scans a doc comment one code point per transaction and reports one token.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     accepted when
//  item     in   ch, at_end, want_example, want_type         valid && ready
//  result   out  token_kind, skip_count, token_length        valid && ready
//
//  one item per cycle sustained while the result register is free; an item is
//  resolved while it sits in the input register, and its result (if any) is
//  written to the result register when the item is consumed
//  the scan state updates as each item is consumed, which sets the one-item rate
//  arst_n clears the scan state and both valid flags; payload registers hold
//  a stalled result holds the result register; the input register then fills
//  and item.ready drops until the result is taken
// ----------------------------------------------------------------------------
module doc_comment_token_scanner #(
	parameter int COUNT_BITS = dcts_pkg::COUNT_BITS_DEF,
	parameter int DEPTH_BITS = dcts_pkg::DEPTH_BITS_DEF
) (
	input wire            clk,
	input wire            arst_n,
	dcts_item_if.sink     item,
	dcts_result_if.source result
);
	import dcts_pkg::*;

	dcts_item_t        in_item;
	dcts_item_slot_t   slot_s1;
	dcts_result_slot_t res;
	dcts_result_t      out_result;
	logic              consume;
	logic              out_free;

	// pack the incoming transaction
	assign in_item = '{ch: item.ch, at_end: item.at_end,
		want_example: item.want_example, want_type: item.want_type};

	dcts_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_item  (in_item),
		.consume  (consume),
		.slot_s1  (slot_s1)
	);

	// character step and scan state
	dcts_scan_core #(
		.COUNT_BITS (COUNT_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_scan_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.slot_s1  (slot_s1),
		.out_free (out_free),
		.consume  (consume),
		.res      (res)
	);

	dcts_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_result (out_result)
	);

	// unpack the outgoing transaction
	assign result.token_kind   = out_result.token_kind;
	assign result.skip_count   = out_result.skip_count;
	assign result.token_length = out_result.token_length;

endmodule
`default_nettype wire
